// ===== design/tfgc_pkg.sv =====
// Shared types, codes and constants for the two finger gesture classifier.
// No dependencies; used by the top level and its checker.
package tfgc_pkg;

   localparam int MAX_CONTACTS_DEF = 4;
   localparam int COORD_BITS_DEF   = 12;

   localparam logic [2:0] OP_PRESS   = 3'd0;
   localparam logic [2:0] OP_MOVE    = 3'd1;
   localparam logic [2:0] OP_RELEASE = 3'd2;
   localparam logic [2:0] OP_TICK    = 3'd3;
   localparam logic [2:0] OP_QUERY   = 3'd4;

   localparam logic [1:0] GEST_NONE     = 2'd0;
   localparam logic [1:0] GEST_MOVE     = 2'd1;
   localparam logic [1:0] GEST_PINCH    = 2'd2;
   localparam logic [1:0] GEST_LONG_TAP = 2'd3;

   localparam logic [1:0] CSR_ACTIVE = 2'd0;
   localparam logic [1:0] CSR_GATE   = 2'd1;
   localparam logic [1:0] CSR_LONG   = 2'd2;

   localparam logic [2:0]  ACTIVE_RST = 3'd4;
   localparam logic [11:0] GATE_RST   = 12'd5;
   localparam logic [15:0] LONG_RST   = 16'd1500;
   localparam logic [15:0] HOLD_MAX   = 16'hFFFF;

   localparam logic signed [63:0] Q16_ONE  = 64'sd65536;
   localparam logic signed [63:0] Q16_HALF = 64'sd32768;
   localparam logic signed [31:0] SAT_MAX  = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SAT_MIN  = 32'sh80000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MV_WAIT,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_Q_A,
      ST_Q_B,
      ST_Q_DEC,
      ST_LT_B,
      ST_MUL,
      ST_P_DEC,
      ST_SQRT,
      ST_DIV,
      ST_P_OUT,
      ST_FIN
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'(SAT_MAX)) r = SAT_MAX;
      else if (v < 64'(SAT_MIN)) r = SAT_MIN;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== design/two_finger_gesture_classifier_unit.sv =====
// Two finger gesture classifier: contact tracking and gesture query.
// Depends on tfgc_pkg.
//
// Each request gives one response. Contact state sits in a small memory with a
// registered read; one request is worked at a time by a sequencer. Press,
// release and ignored requests need no memory read. A move reads its slot before
// writing it back, and a tick reads and updates each slot in use in turn. A query
// with two touched contacts reads both and classifies them; a long tap then
// clears both holds, and a move gesture or a pinch first goes through the shared
// multiplier. A pinch with a nonzero base then runs a bit serial square root and
// the divider. A finished response waits in the output register while the next
// request is taken.
module two_finger_gesture_classifier_unit #(
   parameter int MAX_CONTACTS = tfgc_pkg::MAX_CONTACTS_DEF,
   parameter int COORD_BITS   = tfgc_pkg::COORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic [1:0]         req_contact,
   input  logic [11:0]        req_pos_x,
   input  logic [11:0]        req_pos_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_gesture,
   output logic signed [31:0] rsp_value_x,
   output logic signed [31:0] rsp_value_y,
   output logic [2:0]         rsp_touch_count,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int SW   = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
   localparam int NW   = $clog2(MAX_CONTACTS + 1);
   localparam int DW   = COORD_BITS + 1;
   localparam int EW   = COORD_BITS + 3;
   localparam int PW   = 2 * EW;
   localparam int AW   = 2 * EW + 1;
   localparam int K    = EW + 8;
   localparam int SQW  = 2 * K;
   localparam int SUMW = COORD_BITS + 2;
   localparam int NUMW = SUMW + 24;
   localparam int CW   = $clog2(NUMW + 1);

   typedef struct packed {
      logic [COORD_BITS-1:0]  lx;
      logic [COORD_BITS-1:0]  ly;
      logic signed [DW-1:0]   dx;
      logic signed [DW-1:0]   dy;
      logic [15:0]            hold;
   } entry_type;

   tfgc_pkg::state_type state_ff, state_in;

   entry_type              mem_ff [MAX_CONTACTS];
   entry_type              rdata_ff;
   logic [SW-1:0]          raddr, waddr;
   logic                   wen;
   entry_type              wdata;

   logic [2:0]             active_ff;
   logic [11:0]            gate_ff;
   logic [15:0]            long_ff;
   logic [MAX_CONTACTS-1:0] touched_ff, touched_in;

   logic [SW-1:0]          slot_ff, slot_in, slot_b_ff, slot_b_in, idx_ff, idx_in;
   logic [COORD_BITS-1:0]  x_ff, x_in, y_ff, y_in;
   entry_type              ent_a_ff, ent_a_in, ent_b_ff, ent_b_in;
   logic [1:0]             gest_ff, gest_in;
   logic signed [31:0]     vx_ff, vx_in, vy_ff, vy_in;
   logic signed [AW-1:0]   dot_ff, dot_in, l2_ff, l2_in, d2_ff, d2_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic [CW-1:0]          step_ff, step_in;
   logic                   neg_ff, neg_in;
   logic [SQW-1:0]         rad_ff, rad_in;
   logic [K:0]             srem_ff, srem_in;
   logic [K-1:0]           root_ff, root_in;
   logic [K-1:0]           remx_ff, remx_in, remy_ff, remy_in;
   logic [NUMW-1:0]        numx_ff, numx_in, numy_ff, numy_in;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_gesture_ff;
   logic signed [31:0]     rsp_value_x_ff, rsp_value_y_ff;
   logic [2:0]             rsp_count_ff;
   logic                   rsp_load;
   logic [2:0]             count_now;

   logic [NW-1:0]          n_slots;
   logic [MAX_CONTACTS-1:0] inuse;
   logic                   accept;
   logic                   cfg_clear;

   assign req_stall       = (state_ff != tfgc_pkg::ST_IDLE);
   assign accept          = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gesture     = rsp_gesture_ff;
   assign rsp_value_x     = rsp_value_x_ff;
   assign rsp_value_y     = rsp_value_y_ff;
   assign rsp_touch_count = rsp_count_ff;
   assign cfg_clear       = csr_write && (csr_index == tfgc_pkg::CSR_ACTIVE) &&
                            (csr_wdata[2:0] != active_ff);

   always_comb begin
      n_slots = (int'(active_ff) > MAX_CONTACTS) ? NW'(MAX_CONTACTS) : NW'(active_ff);
      for (int i = 0; i < MAX_CONTACTS; i++) inuse[i] = (i < int'(n_slots));
   end

   // state memory
   always_ff @(posedge clock) begin
      if (wen) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= tfgc_pkg::ACTIVE_RST;
         gate_ff   <= tfgc_pkg::GATE_RST;
         long_ff   <= tfgc_pkg::LONG_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            tfgc_pkg::CSR_ACTIVE: active_ff <= csr_wdata[2:0];
            tfgc_pkg::CSR_GATE:   gate_ff   <= csr_wdata[11:0];
            tfgc_pkg::CSR_LONG:   long_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tfgc_pkg::ST_IDLE;
         touched_ff <= '0;
      end else begin
         state_ff   <= state_in;
         touched_ff <= cfg_clear ? '0 : touched_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      slot_b_ff <= slot_b_in;
      idx_ff   <= idx_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      ent_a_ff <= ent_a_in;
      ent_b_ff <= ent_b_in;
      gest_ff  <= gest_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      dot_ff   <= dot_in;
      l2_ff    <= l2_in;
      d2_ff    <= d2_in;
      prod_ff  <= prod_in;
      step_ff  <= step_in;
      neg_ff   <= neg_in;
      rad_ff   <= rad_in;
      srem_ff  <= srem_in;
      root_ff  <= root_in;
      remx_ff  <= remx_in;
      remy_ff  <= remy_in;
      numx_ff  <= numx_in;
      numy_ff  <= numy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_gesture_ff <= gest_ff;
         rsp_value_x_ff <= vx_ff;
         rsp_value_y_ff <= vy_ff;
         rsp_count_ff   <= count_now;
      end
   end

   always_comb begin
      count_now = '0;
      for (int i = 0; i < MAX_CONTACTS; i++)
         if (inuse[i] && touched_ff[i]) count_now = count_now + 3'd1;
   end

   always_comb begin
      logic [1:0]             cnt;
      logic [SW-1:0]          fa, fb;
      logic                   in_range;
      logic [SW-1:0]          cslot;
      logic [COORD_BITS-1:0]  cx, cy;
      logic signed [DW-1:0]   mdx, mdy, adx, ady;
      logic                   h0, h1;
      logic signed [EW-1:0]   pxa, pya, pxb, pyb, exp, eyp, exl, eyl, ma, mb;
      logic signed [63:0]     tx, ty;
      logic [DW-1:0]          ax0, ax1, ay0, ay1;
      logic [SUMW-1:0]        sx, sy;
      logic [K+2:0]           st;
      logic [K+1:0]           trial;
      logic [K:0]             dtx, dty;

      state_in   = state_ff;
      touched_in = touched_ff;
      slot_in    = slot_ff;
      slot_b_in  = slot_b_ff;
      idx_in     = idx_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      ent_a_in   = ent_a_ff;
      ent_b_in   = ent_b_ff;
      gest_in    = gest_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      dot_in     = dot_ff;
      l2_in      = l2_ff;
      d2_in      = d2_ff;
      prod_in    = prod_ff;
      step_in    = step_ff;
      neg_in     = neg_ff;
      rad_in     = rad_ff;
      srem_in    = srem_ff;
      root_in    = root_ff;
      remx_in    = remx_ff;
      remy_in    = remy_ff;
      numx_in    = numx_ff;
      numy_in    = numy_ff;
      raddr      = slot_ff;
      waddr      = slot_ff;
      wen        = 1'b0;
      wdata      = ent_a_ff;
      rsp_load   = 1'b0;

      // first two touched slots
      cnt = '0;
      fa  = '0;
      fb  = '0;
      for (int i = 0; i < MAX_CONTACTS; i++) begin
         if (inuse[i] && touched_ff[i]) begin
            if (cnt == 2'd0) fa = SW'(i);
            else if (cnt == 2'd1) fb = SW'(i);
            if (cnt != 2'd2) cnt = cnt + 2'd1;
         end
      end

      in_range = int'(req_contact) < int'(n_slots);
      cslot    = SW'(req_contact);
      cx       = COORD_BITS'(req_pos_x);
      cy       = COORD_BITS'(req_pos_y);

      mdx = DW'(signed'({1'b0, x_ff})) - DW'(signed'({1'b0, rdata_ff.lx}));
      mdy = DW'(signed'({1'b0, y_ff})) - DW'(signed'({1'b0, rdata_ff.ly}));
      adx = (mdx < 0) ? -mdx : mdx;
      ady = (mdy < 0) ? -mdy : mdy;

      h0 = (ent_a_ff.dx == '0) && (ent_a_ff.dy == '0);
      h1 = (ent_b_ff.dx == '0) && (ent_b_ff.dy == '0);

      pxa = EW'(signed'({1'b0, ent_a_ff.lx})) - EW'(ent_a_ff.dx);
      pya = EW'(signed'({1'b0, ent_a_ff.ly})) - EW'(ent_a_ff.dy);
      pxb = EW'(signed'({1'b0, ent_b_ff.lx})) - EW'(ent_b_ff.dx);
      pyb = EW'(signed'({1'b0, ent_b_ff.ly})) - EW'(ent_b_ff.dy);
      exp = pxb - pxa;
      eyp = pyb - pya;
      exl = EW'(signed'({1'b0, ent_b_ff.lx})) - EW'(signed'({1'b0, ent_a_ff.lx}));
      eyl = EW'(signed'({1'b0, ent_b_ff.ly})) - EW'(signed'({1'b0, ent_a_ff.ly}));

      case (step_ff)
         CW'(0):  begin ma = EW'(ent_a_ff.dx); mb = EW'(ent_b_ff.dx); end
         CW'(1):  begin ma = EW'(ent_a_ff.dy); mb = EW'(ent_b_ff.dy); end
         CW'(2):  begin ma = exp; mb = exp; end
         CW'(3):  begin ma = eyp; mb = eyp; end
         CW'(4):  begin ma = exl; mb = exl; end
         default: begin ma = eyl; mb = eyl; end
      endcase

      ax0 = (ent_a_ff.dx < 0) ? DW'(-ent_a_ff.dx) : DW'(ent_a_ff.dx);
      ax1 = (ent_b_ff.dx < 0) ? DW'(-ent_b_ff.dx) : DW'(ent_b_ff.dx);
      ay0 = (ent_a_ff.dy < 0) ? DW'(-ent_a_ff.dy) : DW'(ent_a_ff.dy);
      ay1 = (ent_b_ff.dy < 0) ? DW'(-ent_b_ff.dy) : DW'(ent_b_ff.dy);
      sx  = SUMW'(ax0) + SUMW'(ax1);
      sy  = SUMW'(ay0) + SUMW'(ay1);

      tx = 64'sd0;
      ty = 64'sd0;

      st    = {srem_ff, rad_ff[SQW-1 -: 2]};
      trial = {root_ff, 2'b01};
      dtx   = {remx_ff, numx_ff[NUMW-1]};
      dty   = {remy_ff, numy_ff[NUMW-1]};

      unique case (state_ff)
         tfgc_pkg::ST_IDLE: begin
            if (accept) begin
               slot_in = cslot;
               x_in    = cx;
               y_in    = cy;
               gest_in = tfgc_pkg::GEST_NONE;
               vx_in   = '0;
               vy_in   = '0;
               state_in = tfgc_pkg::ST_FIN;
               if (req_op == tfgc_pkg::OP_PRESS ||
                   (req_op == tfgc_pkg::OP_MOVE && !touched_ff[cslot])) begin
                  if (in_range) begin
                     wen        = 1'b1;
                     waddr      = cslot;
                     wdata      = '{lx: cx, ly: cy, dx: '0, dy: '0, hold: '0};
                     touched_in[cslot] = 1'b1;
                  end
               end else if (req_op == tfgc_pkg::OP_MOVE) begin
                  if (in_range) begin
                     raddr    = cslot;
                     state_in = tfgc_pkg::ST_MV_WAIT;
                  end
               end else if (req_op == tfgc_pkg::OP_RELEASE) begin
                  if (in_range) touched_in[cslot] = 1'b0;
               end else if (req_op == tfgc_pkg::OP_TICK) begin
                  if (n_slots != '0) begin
                     idx_in   = '0;
                     state_in = tfgc_pkg::ST_TICK_RD;
                  end
               end else if (req_op == tfgc_pkg::OP_QUERY) begin
                  if (cnt == 2'd2) begin
                     raddr     = fa;
                     slot_in   = fa;
                     slot_b_in = fb;
                     state_in  = tfgc_pkg::ST_Q_A;
                  end
               end
            end
         end
         tfgc_pkg::ST_MV_WAIT: begin
            wen   = 1'b1;
            wdata = '{lx: x_ff, ly: y_ff, dx: mdx, dy: mdy, hold: rdata_ff.hold};
            if (32'(unsigned'(adx)) > 32'(gate_ff) || 32'(unsigned'(ady)) > 32'(gate_ff))
               wdata.hold = '0;
            state_in = tfgc_pkg::ST_FIN;
         end
         tfgc_pkg::ST_TICK_RD: begin
            raddr    = idx_ff;
            state_in = tfgc_pkg::ST_TICK_WR;
         end
         tfgc_pkg::ST_TICK_WR: begin
            waddr = idx_ff;
            wdata = rdata_ff;
            wdata.hold = rdata_ff.hold + 16'd1;
            wen   = touched_ff[idx_ff] && (rdata_ff.hold != tfgc_pkg::HOLD_MAX);
            if (int'(idx_ff) + 1 >= int'(n_slots)) begin
               state_in = tfgc_pkg::ST_FIN;
            end else begin
               idx_in   = idx_ff + SW'(1);
               state_in = tfgc_pkg::ST_TICK_RD;
            end
         end
         tfgc_pkg::ST_Q_A: begin
            ent_a_in = rdata_ff;
            raddr    = slot_b_ff;
            state_in = tfgc_pkg::ST_Q_B;
         end
         tfgc_pkg::ST_Q_B: begin
            ent_b_in = rdata_ff;
            state_in = tfgc_pkg::ST_Q_DEC;
         end
         tfgc_pkg::ST_Q_DEC: begin
            if (h0 && h1) begin
               if (ent_a_ff.hold <= long_ff) begin
                  state_in = tfgc_pkg::ST_FIN;
               end else begin
                  wen   = 1'b1;
                  waddr = slot_ff;
                  wdata = ent_a_ff;
                  wdata.hold = '0;
                  if (ent_b_ff.hold <= long_ff) begin
                     state_in = tfgc_pkg::ST_FIN;
                  end else begin
                     tx = (signed'(64'(ent_a_ff.lx)) + signed'(64'(ent_b_ff.lx))) *
                          tfgc_pkg::Q16_HALF;
                     ty = (signed'(64'(ent_a_ff.ly)) + signed'(64'(ent_b_ff.ly))) *
                          tfgc_pkg::Q16_HALF;
                     gest_in  = tfgc_pkg::GEST_LONG_TAP;
                     vx_in    = tfgc_pkg::sat32(tx);
                     vy_in    = tfgc_pkg::sat32(ty);
                     state_in = tfgc_pkg::ST_LT_B;
                  end
               end
            end else begin
               step_in  = '0;
               state_in = tfgc_pkg::ST_MUL;
            end
         end
         tfgc_pkg::ST_LT_B: begin
            wen   = 1'b1;
            waddr = slot_b_ff;
            wdata = ent_b_ff;
            wdata.hold = '0;
            state_in = tfgc_pkg::ST_FIN;
         end
         tfgc_pkg::ST_MUL: begin
            prod_in = PW'(ma) * PW'(mb);
            case (step_ff)
               CW'(1):  dot_in = AW'(prod_ff);
               CW'(2):  dot_in = dot_ff + AW'(prod_ff);
               CW'(3):  l2_in  = AW'(prod_ff);
               CW'(4):  l2_in  = l2_ff + AW'(prod_ff);
               CW'(5):  d2_in  = AW'(prod_ff);
               CW'(6):  d2_in  = d2_ff + AW'(prod_ff);
               default: ;
            endcase
            step_in = step_ff + CW'(1);
            if (step_ff == CW'(6)) state_in = tfgc_pkg::ST_P_DEC;
         end
         tfgc_pkg::ST_P_DEC: begin
            if (!h0 && !h1 && dot_ff >= 0) begin
               tx = (64'(ent_a_ff.dx) + 64'(ent_b_ff.dx)) * tfgc_pkg::Q16_HALF;
               ty = (64'(ent_a_ff.dy) + 64'(ent_b_ff.dy)) * tfgc_pkg::Q16_HALF;
               gest_in  = tfgc_pkg::GEST_MOVE;
               vx_in    = tfgc_pkg::sat32(tx);
               vy_in    = tfgc_pkg::sat32(ty);
               state_in = tfgc_pkg::ST_FIN;
            end else if (l2_ff == '0) begin
               gest_in  = tfgc_pkg::GEST_PINCH;
               vx_in    = tfgc_pkg::SAT_MAX;
               vy_in    = tfgc_pkg::SAT_MAX;
               state_in = tfgc_pkg::ST_FIN;
            end else begin
               neg_in   = d2_ff < l2_ff;
               numx_in  = {sx, 24'd0};
               numy_in  = {sy, 24'd0};
               rad_in   = {l2_ff[PW-1:0], 16'd0};
               srem_in  = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = tfgc_pkg::ST_SQRT;
            end
         end
         tfgc_pkg::ST_SQRT: begin
            if (st >= (K+3)'(trial)) begin
               srem_in = (K+1)'(st - (K+3)'(trial));
               root_in = {root_ff[K-2:0], 1'b1};
            end else begin
               srem_in = (K+1)'(st);
               root_in = {root_ff[K-2:0], 1'b0};
            end
            rad_in  = {rad_ff[SQW-3:0], 2'b00};
            step_in = step_ff + CW'(1);
            if (step_ff == CW'(K-1)) begin
               remx_in  = '0;
               remy_in  = '0;
               step_in  = '0;
               state_in = tfgc_pkg::ST_DIV;
            end
         end
         tfgc_pkg::ST_DIV: begin
            if (dtx >= {1'b0, root_ff}) begin
               remx_in = K'(dtx - {1'b0, root_ff});
               numx_in = {numx_ff[NUMW-2:0], 1'b1};
            end else begin
               remx_in = K'(dtx);
               numx_in = {numx_ff[NUMW-2:0], 1'b0};
            end
            if (dty >= {1'b0, root_ff}) begin
               remy_in = K'(dty - {1'b0, root_ff});
               numy_in = {numy_ff[NUMW-2:0], 1'b1};
            end else begin
               remy_in = K'(dty);
               numy_in = {numy_ff[NUMW-2:0], 1'b0};
            end
            step_in = step_ff + CW'(1);
            if (step_ff == CW'(NUMW-1)) state_in = tfgc_pkg::ST_P_OUT;
         end
         tfgc_pkg::ST_P_OUT: begin
            tx = signed'(64'(numx_ff));
            ty = signed'(64'(numy_ff));
            gest_in  = tfgc_pkg::GEST_PINCH;
            vx_in    = tfgc_pkg::sat32(neg_ff ? tfgc_pkg::Q16_ONE - tx : tfgc_pkg::Q16_ONE + tx);
            vy_in    = tfgc_pkg::sat32(neg_ff ? tfgc_pkg::Q16_ONE - ty : tfgc_pkg::Q16_ONE + ty);
            state_in = tfgc_pkg::ST_FIN;
         end
         tfgc_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = tfgc_pkg::ST_IDLE;
            end
         end
         default: state_in = tfgc_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== design/tfgc_checker.sv =====
// Port level checks for the two finger gesture classifier, bound to the top.
// Depends on tfgc_pkg and two_finger_gesture_classifier_unit.
module tfgc_checker #(
   parameter int MAX_CONTACTS = tfgc_pkg::MAX_CONTACTS_DEF
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_gesture,
   input logic signed [31:0] rsp_value_x,
   input logic signed [31:0] rsp_value_y,
   input logic [2:0]         rsp_touch_count
);

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gesture == tfgc_pkg::GEST_NONE |->
         rsp_value_x == 0 && rsp_value_y == 0)
      else $error("no gesture with nonzero value");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_touch_count) <= MAX_CONTACTS)
      else $error("touch count above contact slots");

   a_tap_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gesture == tfgc_pkg::GEST_LONG_TAP |->
         !rsp_value_x[31] && !rsp_value_y[31])
      else $error("long tap midpoint negative");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gesture) &&
         $stable(rsp_value_x) && $stable(rsp_value_y) && $stable(rsp_touch_count))
      else $error("stalled response changed");

endmodule

bind two_finger_gesture_classifier_unit tfgc_checker #(
   .MAX_CONTACTS(MAX_CONTACTS)
) u_tfgc_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_gesture(rsp_gesture),
   .rsp_value_x(rsp_value_x),
   .rsp_value_y(rsp_value_y),
   .rsp_touch_count(rsp_touch_count)
);

// ===== bench/two_finger_gesture_classifier_unit_test.sv =====
// Self-checking bench for two_finger_gesture_classifier_unit: a scoreboard
// class predicts each response from request and register history.
// Depends on tfgc_pkg and the unit; needs nothing else.
`timescale 1ns / 1ps

module two_finger_gesture_classifier_unit_test;

   localparam int  SLOTS      = 4;
   localparam int  CYCLE_CAP  = 2000000;
   localparam int  SETTLE     = 150;

   typedef struct {
      logic [1:0]         gesture;
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic [2:0]         touch_count;
   } gesture_result_type;

   class gesture_scoreboard;
      int                 active, gate, long_ticks;
      bit                 touched[SLOTS];
      longint             pt_x[SLOTS], pt_y[SLOTS], mv_x[SLOTS], mv_y[SLOTS];
      int                 hold[SLOTS];
      gesture_result_type pending_q[$];
      int                 errors, matched;
      int                 seen[4];

      function new();
         active = tfgc_pkg::ACTIVE_RST;
         gate = tfgc_pkg::GATE_RST;
         long_ticks = tfgc_pkg::LONG_RST;
         clear_all();
      endfunction

      function void clear_slot(int i);
         touched[i] = 0;
         pt_x[i] = 0; pt_y[i] = 0; mv_x[i] = 0; mv_y[i] = 0; hold[i] = 0;
      endfunction

      function void clear_all();
         for (int i = 0; i < SLOTS; i++) clear_slot(i);
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            tfgc_pkg::CSR_ACTIVE: begin
               if (int'(data[2:0]) != active) begin
                  active = data[2:0];
                  clear_all();
               end
            end
            tfgc_pkg::CSR_GATE: gate = data[11:0];
            tfgc_pkg::CSR_LONG: long_ticks = data;
            default: ;
         endcase
      endfunction

      function longint sat(longint v);
         if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
         if (v < -64'sh80000000) return -64'sh80000000;
         return v;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function longint pinch_axis(longint sum, longint sgn, longint unsigned lq);
         longint unsigned q;
         q = (unsigned'(sum) << 24) / lq;
         return sat(65536 + sgn * longint'(q));
      endfunction

      function logic [1:0] classify(int n, output longint vx, output longint vy);
         int     pick[2];
         int     cnt, a, b;
         longint p0x, p0y, p1x, p1y, ex, ey, len2, dist2, sgn, dot;
         bit     h0, h1;
         longint unsigned lq;
         vx = 0;
         vy = 0;
         cnt = 0;
         for (int i = 0; i < n && cnt < 2; i++)
            if (touched[i]) begin
               pick[cnt] = i;
               cnt++;
            end
         if (cnt != 2) return tfgc_pkg::GEST_NONE;
         a = pick[0];
         b = pick[1];
         p0x = pt_x[a] - mv_x[a]; p0y = pt_y[a] - mv_y[a];
         p1x = pt_x[b] - mv_x[b]; p1y = pt_y[b] - mv_y[b];
         h0 = mv_x[a] == 0 && mv_y[a] == 0;
         h1 = mv_x[b] == 0 && mv_y[b] == 0;
         if (h0 && h1) begin
            if (hold[a] <= long_ticks) return tfgc_pkg::GEST_NONE;
            hold[a] = 0;
            if (hold[b] <= long_ticks) return tfgc_pkg::GEST_NONE;
            hold[b] = 0;
            vx = sat((p0x + p1x) * 32768);
            vy = sat((p0y + p1y) * 32768);
            return tfgc_pkg::GEST_LONG_TAP;
         end
         if (!h0 && !h1) begin
            dot = mv_x[a] * mv_x[b] + mv_y[a] * mv_y[b];
            if (dot >= 0) begin
               vx = sat((mv_x[a] + mv_x[b]) * 32768);
               vy = sat((mv_y[a] + mv_y[b]) * 32768);
               return tfgc_pkg::GEST_MOVE;
            end
         end
         ex = p1x - p0x; ey = p1y - p0y;
         len2 = ex * ex + ey * ey;
         ex = pt_x[b] - pt_x[a]; ey = pt_y[b] - pt_y[a];
         dist2 = ex * ex + ey * ey;
         if (len2 == 0) begin
            vx = 64'sh7FFFFFFF;
            vy = 64'sh7FFFFFFF;
            return tfgc_pkg::GEST_PINCH;
         end
         sgn = dist2 < len2 ? -1 : 1;
         lq = int_sqrt(unsigned'(len2) << 16);
         vx = pinch_axis((mv_x[a] < 0 ? -mv_x[a] : mv_x[a]) +
                         (mv_x[b] < 0 ? -mv_x[b] : mv_x[b]), sgn, lq);
         vy = pinch_axis((mv_y[a] < 0 ? -mv_y[a] : mv_y[a]) +
                         (mv_y[b] < 0 ? -mv_y[b] : mv_y[b]), sgn, lq);
         return tfgc_pkg::GEST_PINCH;
      endfunction

      function void note_request(logic [2:0] op, logic [1:0] c,
                                 logic [11:0] x, logic [11:0] y);
         int                 n, s, cnt;
         longint             dx, dy, vx, vy;
         gesture_result_type r;
         n = active > SLOTS ? SLOTS : active;
         s = c;
         r.gesture = tfgc_pkg::GEST_NONE;
         vx = 0;
         vy = 0;
         if (op <= tfgc_pkg::OP_RELEASE && s < n) begin
            if (op == tfgc_pkg::OP_PRESS || (op == tfgc_pkg::OP_MOVE && !touched[s])) begin
               clear_slot(s);
               touched[s] = 1;
               pt_x[s] = x;
               pt_y[s] = y;
            end else if (op == tfgc_pkg::OP_MOVE) begin
               dx = longint'(x) - pt_x[s];
               dy = longint'(y) - pt_y[s];
               if ((dx < 0 ? -dx : dx) > gate || (dy < 0 ? -dy : dy) > gate)
                  hold[s] = 0;
               mv_x[s] = dx; mv_y[s] = dy;
               pt_x[s] = x;  pt_y[s] = y;
            end else begin
               clear_slot(s);
            end
         end else if (op == tfgc_pkg::OP_TICK) begin
            for (int i = 0; i < n; i++)
               if (touched[i] && hold[i] < tfgc_pkg::HOLD_MAX) hold[i]++;
         end else if (op == tfgc_pkg::OP_QUERY) begin
            r.gesture = classify(n, vx, vy);
         end
         cnt = 0;
         for (int i = 0; i < n; i++)
            if (touched[i]) cnt++;
         r.value_x = vx[31:0];
         r.value_y = vy[31:0];
         r.touch_count = cnt[2:0];
         pending_q.push_back(r);
      endfunction

      function void check_response(logic [1:0] g, logic signed [31:0] vx,
                                   logic signed [31:0] vy, logic [2:0] cnt);
         gesture_result_type e;
         if (pending_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (g !== e.gesture) begin
            $error("gesture: expected %0d, got %0d", e.gesture, g);
            errors++;
         end
         if (vx !== e.value_x) begin
            $error("value_x: expected %0d, got %0d", e.value_x, vx);
            errors++;
         end
         if (vy !== e.value_y) begin
            $error("value_y: expected %0d, got %0d", e.value_y, vy);
            errors++;
         end
         if (cnt !== e.touch_count) begin
            $error("touch_count: expected %0d, got %0d", e.touch_count, cnt);
            errors++;
         end
         seen[e.gesture]++;
         matched++;
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_op = tfgc_pkg::OP_TICK;
   logic [1:0]         req_contact = 2'd0;
   logic [11:0]        req_pos_x = 12'd0;
   logic [11:0]        req_pos_y = 12'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_gesture;
   logic signed [31:0] rsp_value_x;
   logic signed [31:0] rsp_value_y;
   logic [2:0]         rsp_touch_count;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = tfgc_pkg::CSR_ACTIVE;
   logic [15:0]        csr_wdata = 16'd0;

   gesture_scoreboard sb = new();
   int                idle_pct = 36;
   int                cycles = 0;

   two_finger_gesture_classifier_unit u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_gesture, rsp_value_x, rsp_value_y, rsp_touch_count);
      rsp_stall <= !reset && ($urandom_range(99) < idle_pct);
   end

   task automatic send(int op, int c, int x, int y);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op[2:0];
      req_contact <= c[1:0];
      req_pos_x   <= x[11:0];
      req_pos_y   <= y[11:0];
      do @(posedge clock); while (req_stall);
      sb.note_request(op[2:0], c[1:0], x[11:0], y[11:0]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_reg(logic [1:0] idx, logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   function automatic int clip(int v);
      return v < 0 ? 0 : (v > 4095 ? 4095 : v);
   endfunction

   task automatic scenario();
      int a, b, kind, ax, ay, bx, by, d, k;
      a = $urandom_range(3);
      b = (a + 1 + $urandom_range(2)) % 4;
      ax = $urandom_range(4095); ay = $urandom_range(4095);
      bx = $urandom_range(4095); by = $urandom_range(4095);
      d = $urandom_range(1) ? 12 : 300;
      kind = $urandom_range(9);
      if (kind < 8) begin
         send(tfgc_pkg::OP_PRESS, a, ax, ay);
         send(tfgc_pkg::OP_PRESS, b, bx, by);
      end
      case (kind)
         0, 1, 2: begin
            send(tfgc_pkg::OP_MOVE, a, clip(ax + $urandom_range(2 * d) - d),
                 clip(ay + $urandom_range(2 * d) - d));
            send(tfgc_pkg::OP_MOVE, b, clip(bx + $urandom_range(2 * d) - d),
                 clip(by + $urandom_range(2 * d) - d));
            send(tfgc_pkg::OP_QUERY, 0, 0, 0);
         end
         3, 4: begin
            send(tfgc_pkg::OP_MOVE, $urandom_range(1) ? a : b,
                 clip(ax + $urandom_range(2 * d) - d), clip(ay + $urandom_range(2 * d) - d));
            send(tfgc_pkg::OP_QUERY, 0, 0, 0);
         end
         5, 6, 7: begin
            k = $urandom_range(4) + (sb.long_ticks < 8 ? sb.long_ticks : 0);
            repeat (k) send(tfgc_pkg::OP_TICK, 0, 0, 0);
            if ($urandom_range(1)) send(tfgc_pkg::OP_MOVE, a, ax, ay);
            send(tfgc_pkg::OP_QUERY, 0, 0, 0);
            send(tfgc_pkg::OP_QUERY, 0, 0, 0);
         end
         default: begin
            repeat (4) send($urandom_range(7), $urandom_range(3),
                            $urandom_range(4095), $urandom_range(4095));
         end
      endcase
      if ($urandom_range(2) == 0) send(tfgc_pkg::OP_RELEASE, $urandom_range(3), 0, 0);
   endtask

   task automatic phase(int n_items);
      int start;
      start = sb.pending_q.size() + sb.matched;
      while (sb.pending_q.size() + sb.matched - start < n_items) scenario();
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // corners, hold/move/pinch mixes, zero pinch base, unknown ops
      send(tfgc_pkg::OP_PRESS, 0, 0, 0);
      send(tfgc_pkg::OP_PRESS, 1, 4095, 4095);
      send(tfgc_pkg::OP_QUERY, 0, 0, 0);
      send(tfgc_pkg::OP_TICK, 0, 0, 0);
      send(tfgc_pkg::OP_MOVE, 0, 0, 0);
      send(tfgc_pkg::OP_MOVE, 1, 4000, 4095);
      send(tfgc_pkg::OP_QUERY, 0, 0, 0);
      send(tfgc_pkg::OP_MOVE, 0, 10, 10);
      send(tfgc_pkg::OP_QUERY, 0, 0, 0);
      send(tfgc_pkg::OP_PRESS, 0, 100, 100);
      send(tfgc_pkg::OP_PRESS, 1, 100, 100);
      send(tfgc_pkg::OP_MOVE, 0, 110, 100);
      send(tfgc_pkg::OP_MOVE, 1, 90, 100);
      send(tfgc_pkg::OP_QUERY, 0, 0, 0);
      send(tfgc_pkg::OP_MOVE, 0, 4095, 0);
      send(tfgc_pkg::OP_MOVE, 1, 4095, 4);
      send(tfgc_pkg::OP_QUERY, 0, 0, 0);
      send(tfgc_pkg::OP_RELEASE, 1, 0, 0);
      send(tfgc_pkg::OP_QUERY, 0, 0, 0);
      send(tfgc_pkg::OP_RELEASE, 2, 0, 0);
      send(tfgc_pkg::OP_MOVE, 2, 2048, 1024);
      for (int o = int'(tfgc_pkg::OP_QUERY) + 1; o < 8; o++) send(o, 3, 4095, 4095);
      drain();

      phase(90);
      set_reg(tfgc_pkg::CSR_ACTIVE, 16'd2);
      set_reg(tfgc_pkg::CSR_GATE, 16'd0);
      set_reg(tfgc_pkg::CSR_LONG, 16'd0);
      idle_pct = 0;
      phase(110);
      idle_pct = 36;
      set_reg(tfgc_pkg::CSR_ACTIVE, 16'd4);
      set_reg(tfgc_pkg::CSR_GATE, 16'hFFFF);
      set_reg(tfgc_pkg::CSR_LONG, 16'd3);
      phase(110);
      set_reg(tfgc_pkg::CSR_ACTIVE, 16'd1);
      set_reg(tfgc_pkg::CSR_GATE, 16'd100);
      set_reg(tfgc_pkg::CSR_LONG, 16'd2);
      phase(60);
      set_reg(tfgc_pkg::CSR_ACTIVE, 16'hFFFF);
      set_reg(tfgc_pkg::CSR_GATE, 16'd5);
      set_reg(tfgc_pkg::CSR_LONG, 16'd1);
      set_reg(2'd3, 16'h5A5A);
      phase(110);
      set_reg(tfgc_pkg::CSR_ACTIVE, 16'd3);
      set_reg(tfgc_pkg::CSR_GATE, 16'd12);
      set_reg(tfgc_pkg::CSR_LONG, 16'hFFFF);
      phase(90);
      set_reg(tfgc_pkg::CSR_ACTIVE, 16'd0);
      phase(30);
      set_reg(tfgc_pkg::CSR_ACTIVE, 16'd4);
      set_reg(tfgc_pkg::CSR_LONG, 16'd0);
      phase(120);

      if (sb.pending_q.size() != 0) begin
         $error("%0d responses never arrived", sb.pending_q.size());
         sb.errors++;
      end
      $display("Checked %0d responses in %0d cycles: none %0d, move %0d, pinch %0d,",
               sb.matched, cycles, sb.seen[0], sb.seen[1], sb.seen[2]);
      $display("long tap %0d, over eight register settings; %0d mismatches.",
               sb.seen[3], sb.errors);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tfgc_pkg.sv
design/two_finger_gesture_classifier_unit.sv
design/tfgc_checker.sv
bench/two_finger_gesture_classifier_unit_test.sv
